>>> rtl/bptc_pkg.sv
// Package: shared constants and types for the barometer compensation block.
`timescale 1ns / 1ps

package bptc_pkg;

   // Pipeline depth from request acceptance to the result strobe
   localparam int PIPE_DEPTH = 10;

   // Configuration register map (byte address = 4 * index)
   typedef enum logic [2:0] {
      REG_C1   = 3'd0,
      REG_C2   = 3'd1,
      REG_C3   = 3'd2,
      REG_C4   = 3'd3,
      REG_C5   = 3'd4,
      REG_C6   = 3'd5,
      REG_MAXP = 3'd6
   } reg_idx_type;

   localparam int CSR_ADDR_W = 5;
   localparam logic [16:0] MAXP_RESET = 17'd120000;

   // Temperature breakpoints in hundredths of a degree
   localparam int TEMP_REF     = 2000;
   localparam int TEMP_VC_OFS  = 3500;   // offset from cold term to the very cold term

   // Plausibility limits
   localparam int TEMP_OK_MIN  = -6000;
   localparam int TEMP_OK_MAX  = 10000;
   localparam int PRES_OK_MIN  = 10000;

   // Output saturation limits
   localparam int TEMP_OUT_MIN = -8192;
   localparam int TEMP_OUT_MAX = 16383;
   localparam int PRES_OUT_MAX = 131071;

endpackage

>>> rtl/baro_pressure_temperature_compensation.sv
// Top level: pipelined second-order barometer pressure and temperature compensation.
`timescale 1ns / 1ps

// Usage
//   Request channel: drive req_pressure_raw and req_temperature_raw with start high
//   for one cycle; the request is taken at that clock edge. busy is always low, so a
//   new request may be issued in every cycle.
//   Result channel: rsp_valid is high for exactly one cycle with the compensated
//   temperature, pressure and sample_ok flag. Results come out in request order.
//   Throughput: one request per cycle. The ten register stages are the subtract,
//   four parallel multipliers, scaling, two squarers, correction terms, final sums,
//   the split pressure multiply, its recombination, the offset subtract, and the
//   output clamp.
//   Configuration: APB port, register i at byte address 4*i, pready always high.
//   Write calibration only while no request is in flight.
//   Reset: synchronous; clears all in-flight requests and loads the register
//   defaults (calibration words 0, pressure limit 120000 Pa).
//   The receiver cannot stall: each result is shown for one cycle only.
module baro_pressure_temperature_compensation
   import bptc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic [23:0]           req_pressure_raw,
   input  logic [23:0]           req_temperature_raw,
   // result channel
   output logic                  rsp_valid,
   output logic signed [14:0]    rsp_temperature_centi_c,
   output logic [16:0]           rsp_pressure_pa,
   output logic                  rsp_sample_ok,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [15:0] c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;
   logic [15:0] c1_in, c2_in, c3_in, c4_in, c5_in, c6_in;
   logic [16:0] maxp_ff, maxp_in;
   logic        csr_wr;
   reg_idx_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_idx_type'(csr_paddr[4:2]);

   // Decode writes; an index past the map is dropped
   always_comb begin
      c1_in   = c1_ff;
      c2_in   = c2_ff;
      c3_in   = c3_ff;
      c4_in   = c4_ff;
      c5_in   = c5_ff;
      c6_in   = c6_ff;
      maxp_in = maxp_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_C1:   c1_in   = csr_pwdata[15:0];
            REG_C2:   c2_in   = csr_pwdata[15:0];
            REG_C3:   c3_in   = csr_pwdata[15:0];
            REG_C4:   c4_in   = csr_pwdata[15:0];
            REG_C5:   c5_in   = csr_pwdata[15:0];
            REG_C6:   c6_in   = csr_pwdata[15:0];
            REG_MAXP: maxp_in = csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff   <= '0;
         c2_ff   <= '0;
         c3_ff   <= '0;
         c4_ff   <= '0;
         c5_ff   <= '0;
         c6_ff   <= '0;
         maxp_ff <= MAXP_RESET;
      end else begin
         c1_ff   <= c1_in;
         c2_ff   <= c2_in;
         c3_ff   <= c3_in;
         c4_ff   <= c4_in;
         c5_ff   <= c5_in;
         c6_ff   <= c6_in;
         maxp_ff <= maxp_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      case (csr_idx)
         REG_C1:   csr_prdata = {16'd0, c1_ff};
         REG_C2:   csr_prdata = {16'd0, c2_ff};
         REG_C3:   csr_prdata = {16'd0, c3_ff};
         REG_C4:   csr_prdata = {16'd0, c4_ff};
         REG_C5:   csr_prdata = {16'd0, c5_ff};
         REG_C6:   csr_prdata = {16'd0, c6_ff};
         REG_MAXP: csr_prdata = {15'd0, maxp_ff};
         default:  csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Valid bits travel with the data, one per stage
   // ------------------------------------------------------------------
   logic                  accept;
   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Datapath stage signals
   // ------------------------------------------------------------------
   // stage 1: temperature difference
   logic signed [25:0] s1_tdiff_ff, s1_tdiff_in;
   logic        [23:0] s1_praw_ff, s1_praw_in;
   // stage 2: products with the temperature difference
   logic signed [42:0] s2_tk6_ff, s2_tk6_in;
   logic signed [42:0] s2_tk4_ff, s2_tk4_in;
   logic signed [42:0] s2_tk3_ff, s2_tk3_in;
   logic signed [51:0] s2_tt_ff, s2_tt_in;
   logic        [23:0] s2_praw_ff;
   // stage 3: first-order terms
   logic signed [19:0] s3_centi_ff, s3_centi_in;
   logic signed [39:0] s3_ofs_ff, s3_ofs_in;
   logic signed [39:0] s3_gain_ff, s3_gain_in;
   logic        [17:0] s3_tcorr_ff, s3_tcorr_in;
   logic signed [18:0] s3_cold_ff, s3_cold_in;
   logic signed [18:0] s3_vcold_ff, s3_vcold_in;
   logic        [23:0] s3_praw_ff;
   // stage 4: squares
   logic signed [37:0] s4_csq_full, s4_vsq_full;
   logic        [35:0] s4_csq_ff, s4_csq_in;
   logic        [35:0] s4_vsq_ff, s4_vsq_in;
   logic               s4_cold_flag_ff, s4_cold_flag_in;
   logic               s4_vcold_flag_ff, s4_vcold_flag_in;
   logic signed [19:0] s4_centi_ff;
   logic signed [39:0] s4_ofs_ff, s4_gain_ff;
   logic        [17:0] s4_tcorr_ff;
   logic        [23:0] s4_praw_ff;
   // stage 5: second-order corrections
   logic        [39:0] s5_ocorr_ff, s5_ocorr_in;
   logic        [39:0] s5_gcorr_ff, s5_gcorr_in;
   logic        [39:0] s5_c5x, s5_v14x, s5_v11x;
   logic signed [19:0] s5_centi_ff;
   logic signed [39:0] s5_ofs_ff, s5_gain_ff;
   logic        [17:0] s5_tcorr_ff;
   logic        [23:0] s5_praw_ff;
   // stage 6: corrected terms
   logic signed [20:0] s6_centi_ff, s6_centi_in;
   logic signed [40:0] s6_ofs_ff, s6_ofs_in;
   logic signed [40:0] s6_gain_ff, s6_gain_in;
   logic        [23:0] s6_praw_ff;
   // stage 7: split pressure multiply
   logic        [43:0] s7_pplo_ff, s7_pplo_in;
   logic signed [45:0] s7_pphi_ff, s7_pphi_in;
   logic signed [20:0] s7_centi_ff;
   logic signed [40:0] s7_ofs_ff;
   // stage 8: recombined product
   logic signed [63:0] s8_prod_ff, s8_prod_in;
   logic signed [20:0] s8_centi_ff;
   logic signed [40:0] s8_ofs_ff;
   // stage 9: offset removed
   logic signed [44:0] s9_q_ff, s9_q_in;
   logic signed [20:0] s9_centi_ff;
   // stage 10: output register
   logic signed [29:0] s10_pa;
   logic signed [14:0] s10_temp_ff, s10_temp_in;
   logic        [16:0] s10_pres_ff, s10_pres_in;
   logic               s10_ok_ff, s10_ok_in;

   // ------------------------------------------------------------------
   // Combinational work of each stage
   // ------------------------------------------------------------------
   always_comb begin
      // stage 1: difference to the reference temperature reading
      s1_tdiff_in = $signed({2'b00, req_temperature_raw}) - $signed({2'b00, c5_ff, 8'd0});
      s1_praw_in  = req_pressure_raw;

      // stage 2: four parallel multiplies
      s2_tk6_in = s1_tdiff_ff * $signed({1'b0, c6_ff});
      s2_tk4_in = s1_tdiff_ff * $signed({1'b0, c4_ff});
      s2_tk3_in = s1_tdiff_ff * $signed({1'b0, c3_ff});
      s2_tt_in  = s1_tdiff_ff * s1_tdiff_ff;

      // stage 3: scale; taking upper bits floors toward minus infinity
      s3_cold_in  = s2_tk6_ff[41:23];
      s3_centi_in = 20'(s3_cold_in) + 20'(TEMP_REF);
      s3_vcold_in = s3_cold_in + 19'(TEMP_VC_OFS);
      s3_ofs_in   = $signed({7'd0, c2_ff, 17'd0})
                  + $signed({{3{s2_tk4_ff[42]}}, s2_tk4_ff[42:6]});
      s3_gain_in  = $signed({8'd0, c1_ff, 16'd0})
                  + $signed({{4{s2_tk3_ff[42]}}, s2_tk3_ff[42:7]});
      s3_tcorr_in = s2_tt_ff[48:31];

      // stage 4: squares of the cold and very cold distances
      s4_csq_full      = s3_cold_ff * s3_cold_ff;
      s4_vsq_full      = s3_vcold_ff * s3_vcold_ff;
      s4_csq_in        = s4_csq_full[35:0];
      s4_vsq_in        = s4_vsq_full[35:0];
      s4_cold_flag_in  = s3_cold_ff[18];
      s4_vcold_flag_in = s3_vcold_ff[18];

      // stage 5: offset and sensitivity corrections, zero when warm
      s5_c5x  = {s4_csq_ff, 2'b00} + {4'd0, s4_csq_ff};
      s5_v14x = {s4_vsq_ff, 4'b0000} - {3'd0, s4_vsq_ff, 1'b0};
      s5_v11x = {1'b0, s4_vsq_ff, 3'b000} + {3'd0, s4_vsq_ff, 1'b0} + {4'd0, s4_vsq_ff};
      s5_ocorr_in = '0;
      s5_gcorr_in = '0;
      if (s4_cold_flag_ff) begin
         s5_ocorr_in = s5_c5x;
         s5_gcorr_in = {1'b0, s5_c5x[39:1]};
         if (s4_vcold_flag_ff) begin
            s5_ocorr_in = s5_c5x + s5_v14x;
            s5_gcorr_in = {1'b0, s5_c5x[39:1]} + s5_v11x;
         end
      end

      // stage 6: apply the corrections
      s6_centi_in = 21'(s5_centi_ff) - $signed({3'd0, s5_tcorr_ff});
      s6_ofs_in   = 41'(s5_ofs_ff) - $signed({1'b0, s5_ocorr_ff});
      s6_gain_in  = 41'(s5_gain_ff) - $signed({1'b0, s5_gcorr_ff});

      // stage 7: pressure times sensitivity, split at bit 20
      s7_pplo_in = s6_praw_ff * s6_gain_ff[19:0];
      s7_pphi_in = $signed({1'b0, s6_praw_ff}) * $signed(s6_gain_ff[40:20]);

      // stage 8: recombine the partial products
      s8_prod_in = $signed({s7_pphi_ff[43:0], 20'd0}) + $signed({20'd0, s7_pplo_ff});

      // stage 9: scale the product and remove the offset
      s9_q_in = $signed({{2{s8_prod_ff[63]}}, s8_prod_ff[63:21]})
              - $signed({{4{s8_ofs_ff[40]}}, s8_ofs_ff});

      // stage 10: final scale, plausibility check, clamp
      s10_pa    = s9_q_ff[44:15];
      s10_ok_in = (s9_centi_ff >= TEMP_OK_MIN) && (s9_centi_ff <= TEMP_OK_MAX)
               && (s10_pa >= PRES_OK_MIN) && (s10_pa <= $signed({1'b0, maxp_ff}));
      if (s9_centi_ff < TEMP_OUT_MIN) begin
         s10_temp_in = 15'(TEMP_OUT_MIN);
      end else if (s9_centi_ff > TEMP_OUT_MAX) begin
         s10_temp_in = 15'(TEMP_OUT_MAX);
      end else begin
         s10_temp_in = s9_centi_ff[14:0];
      end
      if (s10_pa < 0) begin
         s10_pres_in = '0;
      end else if (s10_pa > PRES_OUT_MAX) begin
         s10_pres_in = 17'(PRES_OUT_MAX);
      end else begin
         s10_pres_in = s10_pa[16:0];
      end
   end

   // ------------------------------------------------------------------
   // Payload registers advance every cycle
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      s1_tdiff_ff      <= s1_tdiff_in;
      s1_praw_ff       <= s1_praw_in;

      s2_tk6_ff        <= s2_tk6_in;
      s2_tk4_ff        <= s2_tk4_in;
      s2_tk3_ff        <= s2_tk3_in;
      s2_tt_ff         <= s2_tt_in;
      s2_praw_ff       <= s1_praw_ff;

      s3_centi_ff      <= s3_centi_in;
      s3_ofs_ff        <= s3_ofs_in;
      s3_gain_ff       <= s3_gain_in;
      s3_tcorr_ff      <= s3_tcorr_in;
      s3_cold_ff       <= s3_cold_in;
      s3_vcold_ff      <= s3_vcold_in;
      s3_praw_ff       <= s2_praw_ff;

      s4_csq_ff        <= s4_csq_in;
      s4_vsq_ff        <= s4_vsq_in;
      s4_cold_flag_ff  <= s4_cold_flag_in;
      s4_vcold_flag_ff <= s4_vcold_flag_in;
      s4_centi_ff      <= s3_centi_ff;
      s4_ofs_ff        <= s3_ofs_ff;
      s4_gain_ff       <= s3_gain_ff;
      s4_tcorr_ff      <= s3_tcorr_ff;
      s4_praw_ff       <= s3_praw_ff;

      s5_ocorr_ff      <= s5_ocorr_in;
      s5_gcorr_ff      <= s5_gcorr_in;
      s5_centi_ff      <= s4_centi_ff;
      s5_ofs_ff        <= s4_ofs_ff;
      s5_gain_ff       <= s4_gain_ff;
      s5_tcorr_ff      <= s4_cold_flag_ff ? s4_tcorr_ff : 18'd0;
      s5_praw_ff       <= s4_praw_ff;

      s6_centi_ff      <= s6_centi_in;
      s6_ofs_ff        <= s6_ofs_in;
      s6_gain_ff       <= s6_gain_in;
      s6_praw_ff       <= s5_praw_ff;

      s7_pplo_ff       <= s7_pplo_in;
      s7_pphi_ff       <= s7_pphi_in;
      s7_centi_ff      <= s6_centi_ff;
      s7_ofs_ff        <= s6_ofs_ff;

      s8_prod_ff       <= s8_prod_in;
      s8_centi_ff      <= s7_centi_ff;
      s8_ofs_ff        <= s7_ofs_ff;

      s9_q_ff          <= s9_q_in;
      s9_centi_ff      <= s8_centi_ff;

      s10_temp_ff      <= s10_temp_in;
      s10_pres_ff      <= s10_pres_in;
      s10_ok_ff        <= s10_ok_in;
   end

   // Drive the result ports
   assign rsp_valid               = valid_ff[PIPE_DEPTH-1];
   assign rsp_temperature_centi_c = s10_temp_ff;
   assign rsp_pressure_pa         = s10_pres_ff;
   assign rsp_sample_ok           = s10_ok_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_DEPTH rsp_valid)
      else $error("accepted request produced no result strobe");

   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, PIPE_DEPTH))
      else $error("result strobe without a matching request");

   a_warm_no_corr: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[3] && !s4_cold_flag_ff) |=> (s5_ocorr_ff == '0 && s5_gcorr_ff == '0))
      else $error("second-order correction applied above the reference temperature");

   a_ok_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sample_ok) |->
         (rsp_pressure_pa >= 17'(PRES_OK_MIN)
          && rsp_temperature_centi_c >= 15'(TEMP_OK_MIN)
          && rsp_temperature_centi_c <= 15'(TEMP_OK_MAX)))
      else $error("sample flagged good outside plausible limits");

   a_maxp_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_idx == REG_MAXP) |=> (maxp_ff == $past(csr_pwdata[16:0])))
      else $error("pressure limit register not written");

endmodule
